// ===== hdl/ihex_pkg.sv =====
`timescale 1ns / 1ps

package ihex_pkg;

  localparam int unsigned MAX_LINE_CHARS = 1023;
  localparam int unsigned POS_W          = 10;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_ESA  = 8'h02;
  localparam logic [7:0] REC_ELA  = 8'h04;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_BAD_SUM   = 3'd4;
  localparam logic [2:0] ST_END_OK    = 3'd5;
  localparam logic [2:0] ST_END_LEN   = 3'd6;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic [2:0]  status;
  } out_word_t;

  typedef struct packed {
    logic        stopped;
    logic [15:0] value;
  } field_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
    return d;
  endfunction

  function automatic field_t feed(input field_t f, input logic [7:0] c);
    field_t     r;
    logic [4:0] d;
    r = f;
    d = hex_digit(c);
    if (!f.stopped) begin
      if (d[4]) r.stopped = 1'b1;
      else r.value = {f.value[11:0], d[3:0]};
    end
    return r;
  endfunction

endpackage

// ===== hdl/intel_hex_record_decoder_core.sv =====
`timescale 1ns / 1ps

// Hex record decoder: takes one ASCII character per word and returns a data-byte word for
// each type 0 data byte after a leading colon (as soon as its second digit arrives) and a
// status word for each line closed by a line feed or end_of_input. A new character can be
// taken every cycle while in_stall is low; each character passes an input register, then
// a result register, before its result word is presented; the per-character field update
// is the one step that sets this rate. While a result word waits under out_stall with a
// character held in the input register, in_stall is raised. After any nonzero status the
// block swallows all further characters without results until reset.
module intel_hex_record_decoder_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ihex_pkg::in_word_t    in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ihex_pkg::out_word_t   out_word
);

  localparam int unsigned PW = ihex_pkg::POS_W;

  ihex_pkg::in_word_t  in_r;
  logic                in_valid_r;
  ihex_pkg::out_word_t out_r, res;
  logic                out_valid_r, res_valid;
  logic                fire;

  logic [PW-1:0] pos_r, pos_nxt;
  logic          line_blank_r, line_blank_nxt;
  logic [7:0]    rec_len_r, rec_len_nxt;
  logic [15:0]   rec_addr_r, rec_addr_nxt;
  logic [7:0]    rec_type_r, rec_type_nxt;
  logic [31:0]   ext_base_r, ext_base_nxt;
  logic [7:0]    run_sum_r, run_sum_nxt;
  ihex_pkg::field_t fld_r, fld_nxt;
  logic [7:0]    byte_idx_r, byte_idx_nxt;
  logic          halted_r, halted_nxt;
  logic          start_ok_r, start_ok_nxt;
  logic          line_long_r, line_long_nxt;
  logic [7:0]    data_sum_r, data_sum_nxt;
  ihex_pkg::field_t ext_r, ext_nxt;
  logic [7:0]    last1_r, last1_nxt;
  logic [7:0]    last2_r, last2_nxt;

  logic [7:0]    c;
  logic          line_end, keep;
  logic [PW-1:0] off, exp_len;
  logic          in_data, fld_start;
  ihex_pkg::field_t fld_f, crc_a, crc_b;
  logic [7:0]    chk_sum;
  logic [2:0]    close_st;

  assign fire      = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = in_valid_r && !fire;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign c        = in_r.char_code;
  assign line_end = in_r.end_of_input || (c == ihex_pkg::CH_LF);
  assign keep     = (c >= ihex_pkg::CH_SPACE) && (c <= ihex_pkg::CH_DEL) &&
                    !(line_blank_r && c == ihex_pkg::CH_SPACE);
  assign off      = pos_r - PW'(9);
  assign in_data  = (pos_r >= PW'(9)) && (off < PW'({rec_len_r, 1'b0}));
  assign fld_start = (pos_r == PW'(1)) || (pos_r == PW'(3)) || (pos_r == PW'(7)) ||
                     (in_data && !off[0]);
  assign fld_f    = ihex_pkg::feed(fld_start ? '0 : fld_r, c);
  assign exp_len  = PW'({rec_len_r, 1'b0}) + PW'(11);
  assign crc_a    = ihex_pkg::feed('0, last2_r);
  assign crc_b    = ihex_pkg::feed(crc_a, last1_r);

  always_comb begin
    chk_sum  = run_sum_r + data_sum_r;
    close_st = ihex_pkg::ST_OK;
    if (pos_r < PW'(3) || !start_ok_r) begin
      close_st = ihex_pkg::ST_BAD_START;
    end else if (line_long_r || pos_r != exp_len) begin
      close_st = ihex_pkg::ST_BAD_LEN;
    end else if (rec_type_r == ihex_pkg::REC_EOF) begin
      close_st = (rec_len_r == 8'd0) ? ihex_pkg::ST_END_OK : ihex_pkg::ST_END_LEN;
    end else if (rec_type_r == ihex_pkg::REC_ESA || rec_type_r == ihex_pkg::REC_ELA) begin
      chk_sum = run_sum_r + ext_r.value[15:8] + ext_r.value[7:0];
      if (rec_len_r != 8'd2) close_st = ihex_pkg::ST_BAD_LEN;
      else if (crc_b.value[7:0] != 8'(8'd0 - chk_sum)) close_st = ihex_pkg::ST_BAD_SUM;
    end else if (rec_type_r == ihex_pkg::REC_DATA) begin
      if (crc_b.value[7:0] != 8'(8'd0 - chk_sum)) close_st = ihex_pkg::ST_BAD_SUM;
    end else begin
      close_st = ihex_pkg::ST_BAD_TYPE;
    end
  end

  always_comb begin
    pos_nxt        = pos_r;
    line_blank_nxt = line_blank_r;
    rec_len_nxt    = rec_len_r;
    rec_addr_nxt   = rec_addr_r;
    rec_type_nxt   = rec_type_r;
    ext_base_nxt   = ext_base_r;
    run_sum_nxt    = run_sum_r;
    fld_nxt        = fld_r;
    byte_idx_nxt   = byte_idx_r;
    halted_nxt     = halted_r;
    start_ok_nxt   = start_ok_r;
    line_long_nxt  = line_long_r;
    data_sum_nxt   = data_sum_r;
    ext_nxt        = ext_r;
    last1_nxt      = last1_r;
    last2_nxt      = last2_r;
    res_valid      = 1'b0;
    res            = '0;
    if (fire && !halted_r) begin
      if (line_end) begin
        res_valid  = 1'b1;
        res.kind   = ihex_pkg::KIND_STATUS;
        res.status = close_st;
        if (close_st != ihex_pkg::ST_OK) halted_nxt = 1'b1;
        if (close_st == ihex_pkg::ST_OK && rec_type_r == ihex_pkg::REC_ESA) begin
          ext_base_nxt = {12'd0, ext_r.value, 4'd0};
        end
        if (close_st == ihex_pkg::ST_OK && rec_type_r == ihex_pkg::REC_ELA) begin
          ext_base_nxt = {ext_r.value, 16'd0};
        end
        pos_nxt        = '0;
        line_blank_nxt = 1'b1;
        rec_len_nxt    = '0;
        rec_addr_nxt   = '0;
        rec_type_nxt   = '0;
        run_sum_nxt    = '0;
        fld_nxt        = '0;
        byte_idx_nxt   = '0;
        start_ok_nxt   = 1'b0;
        line_long_nxt  = 1'b0;
        data_sum_nxt   = '0;
        ext_nxt        = '0;
        last1_nxt      = '0;
        last2_nxt      = '0;
      end else if (keep) begin
        line_blank_nxt = 1'b0;
        if (pos_r >= PW'(ihex_pkg::MAX_LINE_CHARS)) begin
          line_long_nxt = 1'b1;
        end else begin
          if (pos_r == PW'(0)) begin
            start_ok_nxt = (c == ihex_pkg::CH_COLON);
          end else if (pos_r <= PW'(8)) begin
            fld_nxt = fld_f;
            if (pos_r == PW'(2)) begin
              rec_len_nxt = fld_f.value[7:0];
              run_sum_nxt = run_sum_r + fld_f.value[7:0];
            end
            if (pos_r == PW'(6)) begin
              rec_addr_nxt = fld_f.value;
              run_sum_nxt  = run_sum_r + fld_f.value[15:8] + fld_f.value[7:0];
            end
            if (pos_r == PW'(8)) begin
              rec_type_nxt = fld_f.value[7:0];
              run_sum_nxt  = run_sum_r + fld_f.value[7:0];
            end
          end else begin
            if (pos_r <= PW'(12)) ext_nxt = ihex_pkg::feed(ext_r, c);
            if (in_data) begin
              fld_nxt = fld_f;
              if (off[0]) begin
                data_sum_nxt = data_sum_r + fld_f.value[7:0];
                byte_idx_nxt = byte_idx_r + 8'd1;
                if (start_ok_r && rec_type_r == ihex_pkg::REC_DATA) begin
                  res_valid        = 1'b1;
                  res.kind         = ihex_pkg::KIND_DATA;
                  res.byte_address = ({16'd0, rec_addr_r} | ext_base_r) + {24'd0, byte_idx_r};
                  res.data_byte    = fld_f.value[7:0];
                  res.status       = ihex_pkg::ST_OK;
                end
              end
            end
          end
          last2_nxt = last1_r;
          last1_nxt = c;
          pos_nxt   = pos_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pos_r        <= '0;
      line_blank_r <= 1'b1;
      rec_len_r    <= '0;
      rec_addr_r   <= '0;
      rec_type_r   <= '0;
      ext_base_r   <= '0;
      run_sum_r    <= '0;
      fld_r        <= '0;
      byte_idx_r   <= '0;
      halted_r     <= 1'b0;
      start_ok_r   <= 1'b0;
      line_long_r  <= 1'b0;
      data_sum_r   <= '0;
      ext_r        <= '0;
      last1_r      <= '0;
      last2_r      <= '0;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (fire) out_valid_r <= res_valid;
      else if (!out_stall) out_valid_r <= 1'b0;
      pos_r        <= pos_nxt;
      line_blank_r <= line_blank_nxt;
      rec_len_r    <= rec_len_nxt;
      rec_addr_r   <= rec_addr_nxt;
      rec_type_r   <= rec_type_nxt;
      ext_base_r   <= ext_base_nxt;
      run_sum_r    <= run_sum_nxt;
      fld_r        <= fld_nxt;
      byte_idx_r   <= byte_idx_nxt;
      halted_r     <= halted_nxt;
      start_ok_r   <= start_ok_nxt;
      line_long_r  <= line_long_nxt;
      data_sum_r   <= data_sum_nxt;
      ext_r        <= ext_nxt;
      last1_r      <= last1_nxt;
      last2_r      <= last2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) in_r <= in_word;
    if (fire && res_valid) out_r <= res;
  end

  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt cleared without reset");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == ihex_pkg::KIND_STATUS && out_r.status != ihex_pkg::ST_OK)
      |-> halted_r)
    else $error("error status without halt");

  a_no_result_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && !out_valid_r) |=> !out_valid_r)
    else $error("result after halt");

endmodule

// ===== test/intel_hex_record_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module intel_hex_record_decoder_core_tb;

  localparam logic [7:0] CH_CR = 8'h0d;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ihex_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ihex_pkg::out_word_t out_word;

  intel_hex_record_decoder_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  ihex_pkg::in_word_t hex_chars[$];
  ihex_pkg::out_word_t decoded_words[$];
  logic [7:0] line_bytes[$];
  string closing_case;

  int mismatch_count = 0;
  int chars_taken = 0;
  int bytes_seen = 0;
  int statuses_seen = 0;
  int tx_cycle = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  ihex_pkg::out_word_t want;

  // decoder state as the block should hold it
  int dec_pos;
  logic dec_blank;
  logic [7:0] dec_len;
  logic [15:0] dec_addr;
  logic [7:0] dec_type;
  logic [31:0] dec_base;
  logic [7:0] dec_hsum;
  logic [7:0] dec_dsum;
  logic [16:0] dec_field;
  logic [16:0] dec_ext;
  logic [7:0] dec_idx;
  logic dec_halted;
  logic dec_colon;
  logic dec_long;
  logic [7:0] dec_prev1;
  logic [7:0] dec_prev2;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #400_000;
    $display("%0t: timed out with %0d words outstanding", $time, decoded_words.size());
    $display("status: fail");
    $finish;
  end

  // bit 16 marks a field stopped by a non-hex character
  function automatic logic [16:0] take_digit(input logic [16:0] f, input logic [7:0] c);
    if (f[16]) return f;
    if (c >= "0" && c <= "9") return {1'b0, f[11:0], c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b0, f[11:0], c[3:0] + 4'd9};
    return {1'b1, f[15:0]};
  endfunction

  task automatic start_new_line();
    dec_pos = 0;
    dec_blank = 1'b1;
    dec_len = '0;
    dec_addr = '0;
    dec_type = '0;
    dec_hsum = '0;
    dec_dsum = '0;
    dec_field = '0;
    dec_ext = '0;
    dec_idx = '0;
    dec_colon = 1'b0;
    dec_long = 1'b0;
    dec_prev1 = '0;
    dec_prev2 = '0;
  endtask

  function automatic logic [2:0] line_status();
    logic [16:0] crc;
    logic [7:0] sum8;
    if (dec_pos < 3 || !dec_colon) return ihex_pkg::ST_BAD_START;
    if (dec_long || dec_pos != 2 * (int'(dec_len) + 5) + 1) return ihex_pkg::ST_BAD_LEN;
    if (dec_type == ihex_pkg::REC_EOF)
      return (dec_len == 8'd0) ? ihex_pkg::ST_END_OK : ihex_pkg::ST_END_LEN;
    if (dec_type == ihex_pkg::REC_ESA || dec_type == ihex_pkg::REC_ELA) begin
      if (dec_len != 8'd2) return ihex_pkg::ST_BAD_LEN;
      sum8 = dec_hsum + dec_ext[15:8] + dec_ext[7:0];
    end else if (dec_type == ihex_pkg::REC_DATA) begin
      sum8 = dec_hsum + dec_dsum;
    end else begin
      return ihex_pkg::ST_BAD_TYPE;
    end
    crc = take_digit(take_digit(17'd0, dec_prev2), dec_prev1);
    if (crc[7:0] != 8'(8'd0 - sum8)) return ihex_pkg::ST_BAD_SUM;
    if (dec_type == ihex_pkg::REC_ESA) dec_base = {12'd0, dec_ext[15:0], 4'd0};
    if (dec_type == ihex_pkg::REC_ELA) dec_base = {dec_ext[15:0], 16'd0};
    return ihex_pkg::ST_OK;
  endfunction

  task automatic decode_char(input ihex_pkg::in_word_t w);
    ihex_pkg::out_word_t r;
    logic [7:0] c;
    int p;
    int off;
    c = w.char_code;
    r = '0;
    if (dec_halted) return;
    if (w.end_of_input || c == ihex_pkg::CH_LF) begin
      r.kind = ihex_pkg::KIND_STATUS;
      r.status = line_status();
      decoded_words.insert(decoded_words.size(), r);
      if (r.status != ihex_pkg::ST_OK) dec_halted = 1'b1;
      start_new_line();
      return;
    end
    if (c < ihex_pkg::CH_SPACE || c > ihex_pkg::CH_DEL) return;
    if (dec_blank && c == ihex_pkg::CH_SPACE) return;
    dec_blank = 1'b0;
    if (dec_pos >= ihex_pkg::MAX_LINE_CHARS) begin
      dec_long = 1'b1;
      return;
    end
    p = dec_pos;
    if (p == 0) begin
      dec_colon = (c == ihex_pkg::CH_COLON);
    end else if (p <= 2) begin
      if (p == 1) dec_field = '0;
      dec_field = take_digit(dec_field, c);
      if (p == 2) begin
        dec_len = dec_field[7:0];
        dec_hsum = dec_hsum + dec_len;
      end
    end else if (p <= 6) begin
      if (p == 3) dec_field = '0;
      dec_field = take_digit(dec_field, c);
      if (p == 6) begin
        dec_addr = dec_field[15:0];
        dec_hsum = dec_hsum + dec_addr[15:8] + dec_addr[7:0];
      end
    end else if (p <= 8) begin
      if (p == 7) dec_field = '0;
      dec_field = take_digit(dec_field, c);
      if (p == 8) begin
        dec_type = dec_field[7:0];
        dec_hsum = dec_hsum + dec_type;
      end
    end else begin
      if (p <= 12) dec_ext = take_digit(dec_ext, c);
      off = p - 9;
      if (off < 2 * int'(dec_len)) begin
        if (off % 2 == 0) dec_field = '0;
        dec_field = take_digit(dec_field, c);
        if (off % 2 == 1) begin
          dec_dsum = dec_dsum + dec_field[7:0];
          if (dec_colon && dec_type == ihex_pkg::REC_DATA) begin
            r.kind = ihex_pkg::KIND_DATA;
            r.byte_address = ({16'd0, dec_addr} | dec_base) + {24'd0, dec_idx};
            r.data_byte = dec_field[7:0];
            decoded_words.insert(decoded_words.size(), r);
          end
          dec_idx = dec_idx + 8'd1;
        end
      end
    end
    dec_prev2 = dec_prev1;
    dec_prev1 = c;
    dec_pos = p + 1;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [16:0] f;
    c = "0";
    f = take_digit(17'd0, c);
    while (!f[16]) begin
      c = 8'($urandom_range(32, 127));
      f = take_digit(17'd0, c);
    end
    return c;
  endfunction

  // sprinkle dropped characters between kept ones
  task automatic put_char(input logic [7:0] c);
    ihex_pkg::in_word_t w;
    w.end_of_input = 1'b0;
    if ($urandom_range(99) < 4) begin
      w.char_code = $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(31));
      if (w.char_code == ihex_pkg::CH_LF) w.char_code = 8'h00;
      hex_chars.insert(hex_chars.size(), w);
    end
    w.char_code = c;
    hex_chars.insert(hex_chars.size(), w);
  endtask

  task automatic put_end_of_input();
    ihex_pkg::in_word_t w;
    w.char_code = 8'($urandom);
    w.end_of_input = 1'b1;
    hex_chars.insert(hex_chars.size(), w);
  endtask

  task automatic random_bytes(input int n);
    line_bytes.delete();
    repeat (n) line_bytes.insert(line_bytes.size(), 8'($urandom));
  endtask

  task automatic pin_bytes(input logic [7:0] hi, input logic [7:0] lo);
    line_bytes.delete();
    line_bytes.insert(line_bytes.size(), hi);
    line_bytes.insert(line_bytes.size(), lo);
  endtask

  task automatic send_line(input logic [7:0] len_field, input logic [15:0] addr,
                           input logic [7:0] typ, input logic [7:0] lead, input bit messy,
                           input logic [7:0] sum_err);
    logic [7:0] body[$];
    logic [16:0] f;
    logic [7:0] sum8;
    int bad_at;
    int i;
    int k;
    body.insert(body.size(), hex_char(len_field[7:4]));
    body.insert(body.size(), hex_char(len_field[3:0]));
    body.insert(body.size(), hex_char(addr[15:12]));
    body.insert(body.size(), hex_char(addr[11:8]));
    body.insert(body.size(), hex_char(addr[7:4]));
    body.insert(body.size(), hex_char(addr[3:0]));
    body.insert(body.size(), hex_char(typ[7:4]));
    body.insert(body.size(), hex_char(typ[3:0]));
    foreach (line_bytes[j]) begin
      body.insert(body.size(), hex_char(line_bytes[j][7:4]));
      body.insert(body.size(), hex_char(line_bytes[j][3:0]));
    end
    if (messy) begin
      bad_at = $urandom_range(2, body.size() - 1);
      if (bad_at == 6 || bad_at == 7) bad_at = bad_at - 4;
      body[bad_at] = non_hex_char();
    end
    f = '0;
    for (i = 2; i < 6; i++) f = take_digit(f, body[i]);
    sum8 = len_field + typ + f[15:8] + f[7:0];
    for (i = 0; i < int'(len_field) && 9 + 2 * i < body.size(); i++) begin
      f = take_digit(take_digit(17'd0, body[8 + 2 * i]), body[9 + 2 * i]);
      sum8 = sum8 + f[7:0];
    end
    sum8 = 8'd0 - sum8 + sum_err;
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0) put_char(ihex_pkg::CH_SPACE);
    put_char(lead);
    foreach (body[j]) put_char(body[j]);
    put_char(hex_char(sum8[7:4]));
    put_char(hex_char(sum8[3:0]));
    k = $urandom_range(9);
    if (k == 0) begin
      put_end_of_input();
    end else begin
      if (k < 4) put_char(CH_CR);
      put_char(ihex_pkg::CH_LF);
    end
  endtask

  // any nonzero status halts the decoder, so exactly one such line ends the run
  task automatic send_closing_line(input int pick);
    logic [7:0] t;
    int n;
    case (pick)
      0: begin
        closing_case = "end record";
        line_bytes.delete();
        send_line(8'd0, 16'h0000, ihex_pkg::REC_EOF, ihex_pkg::CH_COLON, 1'b0, 8'd0);
      end
      1: begin
        closing_case = "end record with data";
        random_bytes($urandom_range(1, 8));
        send_line(8'(line_bytes.size()), 16'($urandom), ihex_pkg::REC_EOF,
                  ihex_pkg::CH_COLON, 1'b0, 8'd0);
      end
      2: begin
        closing_case = "bad start";
        n = $urandom_range(3);
        if (n == 0) begin
          put_char(ihex_pkg::CH_LF);
        end else if (n == 1) begin
          put_end_of_input();
        end else if (n == 2) begin
          put_char(ihex_pkg::CH_COLON);
          put_char(hex_char(4'($urandom)));
          put_char(ihex_pkg::CH_LF);
        end else begin
          t = ihex_pkg::CH_COLON;
          while (t == ihex_pkg::CH_COLON) t = 8'($urandom_range(33, 126));
          random_bytes($urandom_range(1, 8));
          send_line(8'(line_bytes.size()), 16'($urandom), ihex_pkg::REC_DATA, t, 1'b0,
                    8'd0);
        end
      end
      3: begin
        closing_case = "bad length";
        n = $urandom_range(1, 16);
        random_bytes(n);
        send_line($urandom_range(1) ? 8'(n + 1) : 8'(n - 1), 16'($urandom),
                  ihex_pkg::REC_DATA, ihex_pkg::CH_COLON, 1'b0, 8'd0);
      end
      4: begin
        closing_case = "unsupported type";
        t = ihex_pkg::REC_DATA;
        while (t == ihex_pkg::REC_DATA || t == ihex_pkg::REC_EOF ||
               t == ihex_pkg::REC_ESA || t == ihex_pkg::REC_ELA)
          t = 8'($urandom);
        random_bytes($urandom_range(0, 8));
        send_line(8'(line_bytes.size()), 16'($urandom), t, ihex_pkg::CH_COLON, 1'b0, 8'd0);
      end
      5: begin
        closing_case = "bad checksum";
        random_bytes($urandom_range(1, 16));
        send_line(8'(line_bytes.size()), 16'($urandom), ihex_pkg::REC_DATA,
                  ihex_pkg::CH_COLON, 1'b0, 8'($urandom_range(1, 255)));
      end
      6: begin
        closing_case = "extended record of wrong length";
        n = $urandom_range(0, 4);
        if (n == 2) n = 3;
        random_bytes(n);
        send_line(8'(n), 16'($urandom),
                  $urandom_range(1) ? ihex_pkg::REC_ESA : ihex_pkg::REC_ELA,
                  ihex_pkg::CH_COLON, 1'b0, 8'd0);
      end
      default: begin
        closing_case = "overlong line";
        put_char(ihex_pkg::CH_COLON);
        put_char("F");
        put_char("F");
        repeat (6) put_char("0");
        repeat (1100) put_char(hex_char(4'($urandom)));
        put_char(ihex_pkg::CH_LF);
      end
    endcase
    repeat (20) put_char(8'($urandom));
    put_end_of_input();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      tx_cycle++;
      if (in_valid && !in_stall) begin
        decode_char(in_word);
        chars_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (hex_chars.size() != 0 &&
            !((tx_cycle % 2000 < 1200 || tx_cycle % 2000 >= 1800) &&
              $urandom_range(99) < 32)) begin
          in_word <= hex_chars.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid && !out_stall) begin
        if (decoded_words.size() == 0) begin
          $display("%0t: unexpected word kind=%0d addr=%h data=%h status=%0d", $time,
                   out_word.kind, out_word.byte_address, out_word.data_byte, out_word.status);
          mismatch_count++;
        end else begin
          want = decoded_words.pop_front();
          if (out_word !== want) begin
            $display("%0t: expected kind=%0d addr=%h data=%h status=%0d", $time,
                     want.kind, want.byte_address, want.data_byte, want.status);
            $display("%0t:   actual kind=%0d addr=%h data=%h status=%0d", $time,
                     out_word.kind, out_word.byte_address, out_word.data_byte,
                     out_word.status);
            mismatch_count++;
          end
          if (want.kind == ihex_pkg::KIND_DATA) bytes_seen++;
          else statuses_seen++;
        end
      end
      // hold off long enough to back up the input
      if (rx_cycle == 500) hold_left = 400;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (rx_cycle % 2000 < 1200 || rx_cycle % 2000 >= 1800) &&
                     $urandom_range(99) < 32;
      end
    end
  end

  initial begin : stimulus
    int k;
    int n;
    int waited;
    int closing_pick;
    start_new_line();
    dec_base = '0;
    dec_halted = 1'b0;
    closing_pick = $urandom_range(7);

    put_char(8'h00);
    put_char(8'hff);
    line_bytes.delete();
    send_line(8'd0, 16'h0000, ihex_pkg::REC_DATA, ihex_pkg::CH_COLON, 1'b0, 8'd0);
    pin_bytes(8'hff, 8'hff);
    send_line(8'd2, 16'h0000, ihex_pkg::REC_ELA, ihex_pkg::CH_COLON, 1'b0, 8'd0);
    random_bytes(32);
    send_line(8'd32, 16'hfff0, ihex_pkg::REC_DATA, ihex_pkg::CH_COLON, 1'b0, 8'd0);
    pin_bytes(8'hff, 8'hff);
    send_line(8'd2, 16'h0000, ihex_pkg::REC_ESA, ihex_pkg::CH_COLON, 1'b0, 8'd0);
    pin_bytes(8'h00, 8'hff);
    send_line(8'd2, 16'hffff, ihex_pkg::REC_DATA, ihex_pkg::CH_COLON, 1'b0, 8'd0);
    pin_bytes(8'h00, 8'h00);
    send_line(8'd2, 16'h0000, ihex_pkg::REC_ELA, ihex_pkg::CH_COLON, 1'b0, 8'd0);
    repeat (3) begin
      random_bytes($urandom_range(1, 6));
      send_line(8'(line_bytes.size()), 16'($urandom), ihex_pkg::REC_DATA,
                ihex_pkg::CH_COLON, 1'b1, 8'd0);
    end

    while (hex_chars.size() < ((closing_pick == 7) ? 450 : 1500)) begin
      k = $urandom_range(99);
      if (k < 12) begin
        random_bytes(2);
        send_line(8'd2, 16'($urandom), ihex_pkg::REC_ELA, ihex_pkg::CH_COLON, 1'b0, 8'd0);
      end else if (k < 24) begin
        random_bytes(2);
        send_line(8'd2, 16'($urandom), ihex_pkg::REC_ESA, ihex_pkg::CH_COLON, 1'b0, 8'd0);
      end else begin
        n = (k < 26) ? 255 : ((k < 40) ? $urandom_range(17, 64) : $urandom_range(0, 16));
        random_bytes(n);
        send_line(8'(n), 16'($urandom), ihex_pkg::REC_DATA, ihex_pkg::CH_COLON,
                  $urandom_range(3) == 0, 8'd0);
      end
    end
    send_closing_line(closing_pick);

    wait (rst_n);
    while (hex_chars.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (decoded_words.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (decoded_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, decoded_words.size());
      mismatch_count++;
    end
    $display("run covered %0d characters, %0d data bytes and %0d line statuses",
             chars_taken, bytes_seen, statuses_seen);
    $display("decoding was ended by: %s", closing_case);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
